/* src/pwmdc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pwmdc_pkg
// Shared constants, types and codes of the PWM duty-cycle meter.
// ----------------------------------------------------------------------------
package pwmdc_pkg;

    localparam int WINDOW_DEPTH = 8;
    localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int VAL_W        = 16;
    localparam int SUM_W        = VAL_W + CNT_W;
    localparam int STEP_W       = $clog2(VAL_W);
    localparam int TIME_W       = 32;
    localparam int LIMIT_W      = 16;
    localparam int TIMEOUT_W    = 24;
    localparam int DUTY_W       = 17;
    localparam int IN_W         = 40;
    localparam int OUT_W        = 24;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 24;

    localparam logic [DUTY_W-1:0]    DUTY_ONE          = DUTY_W'(65536);
    localparam logic [DUTY_W-1:0]    DUTY_ZERO         = '0;
    localparam logic [LIMIT_W-1:0]   VALID_LIMIT_RESET = LIMIT_W'(2500);
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET     = TIMEOUT_W'(100000);

    localparam logic [CFG_IDX_W-1:0] CFG_VALID_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        TOP_IDLE,
        TOP_CHECK,
        TOP_AVG,
        TOP_RATIO,
        TOP_EMIT
    } top_state_t;

    typedef enum logic [1:0] {
        WIN_IDLE,
        WIN_SCAN,
        WIN_DIV,
        WIN_DONE
    } win_state_t;

    typedef enum logic [1:0] {
        RAT_IDLE,
        RAT_RUN,
        RAT_DONE
    } rat_state_t;

    // Write request into one timing window.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] value;
        logic             ok;
    } win_wr_t;

endpackage : pwmdc_pkg
`default_nettype wire

/* src/pwmdc_window.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pwmdc_window
// Ring of timings with a serial scan that sums the valid entries and a
// bit-serial divider that yields their truncated mean.
// ----------------------------------------------------------------------------
module pwmdc_window (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire pwmdc_pkg::win_wr_t            wr,
    input  wire logic                          start,
    input  wire logic [pwmdc_pkg::LIMIT_W-1:0] limit,
    output logic                               done,
    output logic [pwmdc_pkg::VAL_W-1:0]        mean
);
    import pwmdc_pkg::*;

    win_state_t        state_reg, state_next;
    logic [VAL_W-1:0]  val_reg [WINDOW_DEPTH];
    logic              ok_reg  [WINDOW_DEPTH];
    logic [IDX_W-1:0]  scan_reg, scan_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              counts;
    logic [CNT_W:0]    rem2;
    logic              ge;
    logic              scan_last;
    logic              step_last;

    assign scan_last = (scan_reg == IDX_W'(WINDOW_DEPTH - 1));
    assign step_last = (step_reg == STEP_W'(VAL_W - 1));
    assign counts    = ok_reg[scan_reg] && (val_reg[scan_reg] < limit);
    assign rem2      = {rem_reg, sum_reg[VAL_W-1]};
    assign ge        = (rem2 >= {1'b0, cnt_reg});

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            WIN_IDLE: if (start) state_next = WIN_SCAN;
            WIN_SCAN: if (scan_last) state_next = WIN_DIV;
            WIN_DIV:  if (step_last) state_next = WIN_DONE;
            WIN_DONE: state_next = WIN_IDLE;
            default:  state_next = WIN_IDLE;
        endcase
    end

    always_comb begin
        done = (state_reg == WIN_DONE);
        mean = (cnt_reg == '0) ? '0 : sum_reg[VAL_W-1:0];
    end

    always_comb begin
        scan_next = scan_reg;
        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        case (state_reg)
            WIN_IDLE: begin
                scan_next = '0;
                sum_next  = '0;
                cnt_next  = '0;
            end
            WIN_SCAN: begin
                if (counts) begin
                    sum_next = sum_reg + SUM_W'(val_reg[scan_reg]);
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                scan_next = scan_reg + IDX_W'(1);
                rem_next  = sum_next[SUM_W-1:VAL_W];
                step_next = '0;
            end
            WIN_DIV: begin
                rem_next  = ge ? CNT_W'(rem2 - {1'b0, cnt_reg}) : rem2[CNT_W-1:0];
                sum_next  = {sum_reg[SUM_W-1:VAL_W], sum_reg[VAL_W-2:0], ge};
                step_next = step_reg + STEP_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= WIN_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        scan_reg <= scan_next;
        sum_reg  <= sum_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                ok_reg[i] <= 1'b0;
            end
        end else if (wr.en) begin
            ok_reg[wr.idx] <= wr.ok;
        end
        if (wr.en) begin
            val_reg[wr.idx] <= wr.value;
        end
    end

endmodule : pwmdc_window
`default_nettype wire

/* src/pwmdc_ratio.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pwmdc_ratio
// Bit-serial divider for the duty ratio of the mean high time over the
// mean period, in Q1.16 with saturation at one.
// ----------------------------------------------------------------------------
module pwmdc_ratio (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [pwmdc_pkg::VAL_W-1:0]  hi,
    input  wire logic [pwmdc_pkg::VAL_W-1:0]  per,
    output logic                              done,
    output logic [pwmdc_pkg::DUTY_W-1:0]      duty
);
    import pwmdc_pkg::*;

    rat_state_t        state_reg, state_next;
    logic [VAL_W-1:0]  hi_reg, hi_next;
    logic [VAL_W-1:0]  per_reg, per_next;
    logic [VAL_W-1:0]  rem_reg, rem_next;
    logic [VAL_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [VAL_W:0]    rem2;
    logic              ge;
    logic              step_last;

    assign rem2      = {rem_reg, 1'b0};
    assign ge        = (rem2 >= {1'b0, per_reg});
    assign step_last = (step_reg == STEP_W'(VAL_W - 1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            RAT_IDLE: if (start) state_next = RAT_RUN;
            RAT_RUN:  if (step_last) state_next = RAT_DONE;
            RAT_DONE: state_next = RAT_IDLE;
            default:  state_next = RAT_IDLE;
        endcase
    end

    always_comb begin
        done = (state_reg == RAT_DONE);
        if (per_reg == '0) begin
            duty = DUTY_ZERO;
        end else if (hi_reg >= per_reg) begin
            duty = DUTY_ONE;
        end else begin
            duty = {1'b0, quo_reg};
        end
    end

    always_comb begin
        hi_next   = hi_reg;
        per_next  = per_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        case (state_reg)
            RAT_IDLE: begin
                if (start) begin
                    hi_next  = hi;
                    per_next = per;
                    rem_next = hi;
                end
                step_next = '0;
            end
            RAT_RUN: begin
                rem_next  = ge ? VAL_W'(rem2 - {1'b0, per_reg}) : rem2[VAL_W-1:0];
                quo_next  = {quo_reg[VAL_W-2:0], ge};
                step_next = step_reg + STEP_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= RAT_IDLE;
        end else begin
            state_reg <= state_next;
        end
        hi_reg   <= hi_next;
        per_reg  <= per_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
    end

endmodule : pwmdc_ratio
`default_nettype wire

/* src/pwm_duty_cycle_meter_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_duty_cycle_meter_core
// Measures PWM period and high time from timestamped pin samples and reports
// the duty cycle in Q1.16 for every sample.
// ----------------------------------------------------------------------------
// One sample is processed at a time and each yields one result; a new
// sample is taken only after the previous result is loaded into the output
// register. A sample that repeats the current level goes from the check
// state straight to the emit state. A sample with a level change passes
// through the window scans, the mean dividers and the ratio divider first.
// Both rings are scanned one entry per cycle, each mean comes from a 16-step
// bit-serial divider, and the ratio comes from a second 16-step bit-serial
// divider. The result sits in an output register; the emit state waits until
// a stalled result there is taken, so it holds up the work on the next one.
// ----------------------------------------------------------------------------
module pwm_duty_cycle_meter_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // s_tdata: pin_level [0], time_us [32:1], zero [39:33]
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [pwmdc_pkg::IN_W-1:0]       s_tdata,
    // m_tdata: duty [16:0], level [17], zero [23:18]
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [pwmdc_pkg::OUT_W-1:0]           m_tdata,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [pwmdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pwmdc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pwmdc_pkg::*;

    top_state_t           state_reg, state_next;
    logic                 level_reg, level_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [TIME_W-1:0]    rise_reg, rise_next;
    logic [TIME_W-1:0]    change_reg, change_next;
    logic [DUTY_W-1:0]    duty_reg, duty_next;
    logic                 pin_reg;
    logic [TIME_W-1:0]    time_reg;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]     m_data_reg, m_data_next;

    logic                 s_accept;
    logic                 changed;
    logic [TIME_W-1:0]    since_rise;
    logic [TIME_W-1:0]    since_change;
    logic                 out_free;
    logic                 win_start;
    logic                 rat_start;
    win_wr_t              cyc_wr;
    win_wr_t              high_wr;
    logic                 cyc_done;
    logic                 high_done;
    logic [VAL_W-1:0]     cyc_mean;
    logic [VAL_W-1:0]     high_mean;
    logic                 rat_done;
    logic [DUTY_W-1:0]    rat_duty;

    assign s_accept     = s_tvalid && s_tready;
    assign changed      = (pin_reg != level_reg);
    assign since_rise   = time_reg - rise_reg;
    assign since_change = time_reg - change_reg;
    assign out_free     = !m_valid_reg || m_tready;
    assign cfg_ready    = 1'b1;
    assign m_tvalid     = m_valid_reg;
    assign m_tdata      = m_data_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            TOP_IDLE:  if (s_accept) state_next = TOP_CHECK;
            TOP_CHECK: state_next = changed ? TOP_AVG : TOP_EMIT;
            TOP_AVG:   if (cyc_done) state_next = TOP_RATIO;
            TOP_RATIO: if (rat_done) state_next = TOP_EMIT;
            TOP_EMIT:  if (out_free) state_next = TOP_IDLE;
            default:   state_next = TOP_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = (state_reg == TOP_IDLE);
        win_start     = (state_reg == TOP_CHECK) && changed;
        rat_start     = (state_reg == TOP_AVG) && cyc_done;
        cyc_wr.en     = win_start && pin_reg;
        cyc_wr.idx    = idx_reg;
        cyc_wr.value  = since_rise[VAL_W-1:0];
        cyc_wr.ok     = (since_rise[TIME_W-1:VAL_W] == '0) && (since_rise[VAL_W-1:0] != '0);
        high_wr.en    = win_start && !pin_reg;
        high_wr.idx   = idx_reg;
        high_wr.value = since_rise[VAL_W-1:0];
        high_wr.ok    = cyc_wr.ok;
    end

    always_comb begin
        level_next   = level_reg;
        idx_next     = idx_reg;
        rise_next    = rise_reg;
        change_next  = change_reg;
        duty_next    = duty_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            TOP_CHECK: begin
                if (changed) begin
                    level_next  = pin_reg;
                    change_next = time_reg;
                    if (pin_reg) begin
                        rise_next = time_reg;
                    end else if (idx_reg == IDX_W'(WINDOW_DEPTH - 1)) begin
                        idx_next = '0;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end else if (since_change > TIME_W'(timeout_reg)) begin
                    duty_next = level_reg ? DUTY_ONE : DUTY_ZERO;
                end
            end
            TOP_RATIO: begin
                if (rat_done) begin
                    duty_next = rat_duty;
                end
            end
            TOP_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {(OUT_W - DUTY_W - 1)'(0), level_reg, duty_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= TOP_IDLE;
            level_reg   <= 1'b0;
            idx_reg     <= '0;
            rise_reg    <= '0;
            change_reg  <= '0;
            duty_reg    <= DUTY_ZERO;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            level_reg   <= level_next;
            idx_reg     <= idx_next;
            rise_reg    <= rise_next;
            change_reg  <= change_next;
            duty_reg    <= duty_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
        if (s_accept) begin
            pin_reg  <= s_tdata[0];
            time_reg <= s_tdata[TIME_W:1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= VALID_LIMIT_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_VALID_LIMIT: limit_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_TIMEOUT:     timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    pwmdc_window u_cycle_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (cyc_wr),
        .start   (win_start),
        .limit   (limit_reg),
        .done    (cyc_done),
        .mean    (cyc_mean)
    );

    pwmdc_window u_high_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (high_wr),
        .start   (win_start),
        .limit   (limit_reg),
        .done    (high_done),
        .mean    (high_mean)
    );

    pwmdc_ratio u_ratio (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rat_start && high_done),
        .hi      (high_mean),
        .per     (cyc_mean),
        .done    (rat_done),
        .duty    (rat_duty)
    );

endmodule : pwm_duty_cycle_meter_core
`default_nettype wire

/* src/pwmdc_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pwmdc_checker
// Port-level checks of the PWM duty-cycle meter, bound to the top level.
// ----------------------------------------------------------------------------
module pwmdc_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_tvalid,
    input wire logic                       s_tready,
    input wire logic                       m_tvalid,
    input wire logic                       m_tready,
    input wire logic [pwmdc_pkg::OUT_W-1:0] m_tdata
);
    import pwmdc_pkg::*;

    // A stalled result must hold.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Duty never exceeds one.
    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[DUTY_W-1] == 1'b0) || (m_tdata[DUTY_W-2:0] == '0))
        else $error("duty above one");

    // Requests are taken one at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

endmodule : pwmdc_checker

bind pwm_duty_cycle_meter_core pwmdc_checker u_pwmdc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
